// ----- hdl/easy_backfill_scheduler_unit_assert.svh -----
// Assertion macros used by the scheduler top level.
// Needs nothing else; take it in with a bare include.
`ifndef EASY_BACKFILL_SCHEDULER_UNIT_ASSERT_SVH
`define EASY_BACKFILL_SCHEDULER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define EBS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define EBS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/ebs_pkg.sv -----
// Shared types, sizes and helper functions of the backfill scheduler.
// Used by ebs_ctrl, ebs_datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package ebs_pkg;

   localparam int MAX_HOSTS   = 64;
   localparam int QUEUE_DEPTH = 32;
   localparam int RUN_DEPTH   = 32;

   localparam int QA_W   = $clog2(QUEUE_DEPTH);
   localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int RA_W   = $clog2(RUN_DEPTH);
   localparam int PLAT_W = 7;
   localparam int HOST_W = $clog2(MAX_HOSTS + 1);
   localparam int TAG_W  = 8;
   localparam int REQH_W = 16;
   localparam int WALL_W = 32;
   localparam int NOW_W  = 40;
   localparam int END_W  = 41;
   localparam int SUM_W  = $clog2(MAX_HOSTS * (RUN_DEPTH + 1) + 1);

   typedef enum logic [1:0] {
      OP_SUBMIT   = 2'd0,
      OP_COMPLETE = 2'd1,
      OP_SCHEDULE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      KIND_LAUNCH = 2'd0,
      KIND_REJECT = 2'd1,
      KIND_DONE   = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_REJECT,
      S_HEAD,
      S_ALLOC,
      S_LAUNCH,
      S_SH_CAND,
      S_SH_SUM,
      S_SH_TEST,
      S_SH_END,
      S_BACKFILL,
      S_DONE
   } state_type;

   typedef struct packed {
      logic     latch_in;
      logic     enqueue;
      logic     complete;
      logic     idx_clr;
      logic     idx_set1;
      logic     idx_inc;
      logic     alloc_init;
      logic     alloc_step;
      logic     launch;
      logic     found_clr;
      logic     shadow_now;
      logic     cand_clr;
      logic     cand_inc;
      logic     sum_init;
      logic     sum_step;
      logic     sh_test;
      logic     emit;
      kind_type kind;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       reject;
      logic       q_empty;
      logic       cur_fits;
      logic       avail_ok;
      logic       cur_ends;
      logic       idx_end;
      logic       alloc_done;
      logic       cand_use;
      logic       cand_last;
      logic       j_last;
      logic       found;
      logic       out_free;
   } sts_type;

   function automatic logic [HOST_W-1:0] popcount(input logic [MAX_HOSTS-1:0] m);
      logic [HOST_W-1:0] c;
      c = '0;
      for (int b = 0; b < MAX_HOSTS; b++) begin
         c = c + HOST_W'(m[b]);
      end
      return c;
   endfunction

   function automatic logic [MAX_HOSTS-1:0] plat_ones(input logic [PLAT_W-1:0] plat);
      logic [MAX_HOSTS-1:0] ones;
      for (int b = 0; b < MAX_HOSTS; b++) begin
         ones[b] = (PLAT_W'(b) < plat);
      end
      return ones;
   endfunction

   function automatic logic [PLAT_W-1:0] clamp_plat(input logic [PLAT_W-1:0] v);
      logic [PLAT_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = PLAT_W'(1);
      end else if (v > PLAT_W'(MAX_HOSTS)) begin
         r = PLAT_W'(MAX_HOSTS);
      end
      return r;
   endfunction

endpackage

// ----- hdl/ebs_ctrl.sv -----
// Controller state machine of the backfill scheduler.
// Drives ebs_datapath through ebs_pkg::cmd_type and reads ebs_pkg::sts_type.
`timescale 1ns / 1ps

module ebs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ebs_pkg::sts_type sts,
   output ebs_pkg::cmd_type cmd
);

   ebs_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ebs_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ebs_pkg::S_IDLE: begin
            if (req_valid) state_in = ebs_pkg::S_DECODE;
         end
         ebs_pkg::S_DECODE: begin
            priority case (sts.op)
               ebs_pkg::OP_SUBMIT:
                  state_in = sts.reject ? ebs_pkg::S_REJECT : ebs_pkg::S_IDLE;
               ebs_pkg::OP_SCHEDULE: state_in = ebs_pkg::S_HEAD;
               default: state_in = ebs_pkg::S_IDLE;
            endcase
         end
         ebs_pkg::S_REJECT: begin
            if (sts.out_free) state_in = ebs_pkg::S_IDLE;
         end
         ebs_pkg::S_HEAD: begin
            priority if (sts.q_empty) state_in = ebs_pkg::S_DONE;
            else if (sts.cur_fits) state_in = ebs_pkg::S_ALLOC;
            else if (sts.avail_ok) state_in = ebs_pkg::S_SH_END;
            else state_in = ebs_pkg::S_SH_CAND;
         end
         ebs_pkg::S_ALLOC: begin
            if (sts.alloc_done) state_in = ebs_pkg::S_LAUNCH;
         end
         ebs_pkg::S_LAUNCH: begin
            // The found flag tells the backfill phase from the first-come phase.
            if (sts.out_free) begin
               state_in = sts.found ? ebs_pkg::S_BACKFILL : ebs_pkg::S_HEAD;
            end
         end
         ebs_pkg::S_SH_CAND: begin
            priority if (sts.cand_use) state_in = ebs_pkg::S_SH_SUM;
            else if (sts.cand_last) state_in = ebs_pkg::S_SH_END;
            else state_in = ebs_pkg::S_SH_CAND;
         end
         ebs_pkg::S_SH_SUM: begin
            if (sts.j_last) state_in = ebs_pkg::S_SH_TEST;
         end
         ebs_pkg::S_SH_TEST: begin
            state_in = sts.cand_last ? ebs_pkg::S_SH_END : ebs_pkg::S_SH_CAND;
         end
         ebs_pkg::S_SH_END: begin
            state_in = sts.found ? ebs_pkg::S_BACKFILL : ebs_pkg::S_DONE;
         end
         ebs_pkg::S_BACKFILL: begin
            priority if (sts.idx_end) state_in = ebs_pkg::S_DONE;
            else if (sts.cur_fits && sts.cur_ends) state_in = ebs_pkg::S_ALLOC;
            else state_in = ebs_pkg::S_BACKFILL;
         end
         ebs_pkg::S_DONE: begin
            if (sts.out_free) state_in = ebs_pkg::S_IDLE;
         end
         default: state_in = ebs_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.kind  = ebs_pkg::KIND_LAUNCH;
      req_ready = 1'b0;
      unique case (state_ff)
         ebs_pkg::S_IDLE: begin
            req_ready    = 1'b1;
            cmd.latch_in = req_valid;
         end
         ebs_pkg::S_DECODE: begin
            priority case (sts.op)
               ebs_pkg::OP_SUBMIT: cmd.enqueue = !sts.reject;
               ebs_pkg::OP_COMPLETE: cmd.complete = 1'b1;
               ebs_pkg::OP_SCHEDULE: begin
                  cmd.idx_clr   = 1'b1;
                  cmd.found_clr = 1'b1;
               end
               default: cmd.latch_in = 1'b0;
            endcase
         end
         ebs_pkg::S_REJECT: begin
            cmd.emit = sts.out_free;
            cmd.kind = ebs_pkg::KIND_REJECT;
         end
         ebs_pkg::S_HEAD: begin
            if (!sts.q_empty) begin
               priority if (sts.cur_fits) cmd.alloc_init = 1'b1;
               else if (sts.avail_ok) cmd.shadow_now = 1'b1;
               else cmd.cand_clr = 1'b1;
            end
         end
         ebs_pkg::S_ALLOC: begin
            cmd.alloc_step = !sts.alloc_done;
         end
         ebs_pkg::S_LAUNCH: begin
            cmd.launch = sts.out_free;
            cmd.emit   = sts.out_free;
            cmd.kind   = ebs_pkg::KIND_LAUNCH;
         end
         ebs_pkg::S_SH_CAND: begin
            cmd.sum_init = sts.cand_use;
            cmd.cand_inc = !sts.cand_use && !sts.cand_last;
         end
         ebs_pkg::S_SH_SUM: begin
            cmd.sum_step = 1'b1;
         end
         ebs_pkg::S_SH_TEST: begin
            cmd.sh_test  = 1'b1;
            cmd.cand_inc = !sts.cand_last;
         end
         ebs_pkg::S_SH_END: begin
            cmd.idx_set1 = sts.found;
         end
         ebs_pkg::S_BACKFILL: begin
            if (!sts.idx_end) begin
               cmd.alloc_init = sts.cur_fits && sts.cur_ends;
               cmd.idx_inc    = !(sts.cur_fits && sts.cur_ends);
            end
         end
         ebs_pkg::S_DONE: begin
            cmd.emit = sts.out_free;
            cmd.kind = ebs_pkg::KIND_DONE;
         end
         default: cmd = '0;
      endcase
   end

endmodule

// ----- hdl/ebs_datapath.sv -----
// Datapath of the backfill scheduler: wait queue, running table, host masks,
// shadow search and the result register. Uses ebs_pkg; driven by ebs_ctrl.
`timescale 1ns / 1ps

module ebs_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  ebs_pkg::cmd_type             cmd,
   output ebs_pkg::sts_type             sts,
   input  logic [1:0]                   req_op,
   input  logic [ebs_pkg::TAG_W-1:0]    req_job_tag,
   input  logic [ebs_pkg::REQH_W-1:0]   req_hosts_requested,
   input  logic [ebs_pkg::WALL_W-1:0]   req_walltime,
   input  logic [ebs_pkg::NOW_W-1:0]    req_now,
   input  logic                         csr_write_enable,
   input  logic [ebs_pkg::PLAT_W-1:0]   csr_write_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_kind,
   output logic [ebs_pkg::TAG_W-1:0]    rsp_out_tag,
   output logic [ebs_pkg::MAX_HOSTS-1:0] rsp_host_mask,
   output logic                         rsp_last
);

   localparam int QD = ebs_pkg::QUEUE_DEPTH;
   localparam int RD = ebs_pkg::RUN_DEPTH;
   localparam int MH = ebs_pkg::MAX_HOSTS;

   // Control state.
   logic [ebs_pkg::PLAT_W-1:0] plat_ff, plat_in;
   logic [MH-1:0]              free_ff, free_in;
   logic [ebs_pkg::QC_W-1:0]   q_cnt_ff, q_cnt_in;
   logic [RD-1:0]              r_valid_ff, r_valid_in;
   logic                       found_ff, found_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // Payload state.
   logic [ebs_pkg::TAG_W-1:0]  q_tag_ff [QD], q_tag_in [QD];
   logic [ebs_pkg::HOST_W-1:0] q_hosts_ff [QD], q_hosts_in [QD];
   logic [ebs_pkg::WALL_W-1:0] q_wall_ff [QD], q_wall_in [QD];
   logic [ebs_pkg::TAG_W-1:0]  r_tag_ff [RD], r_tag_in [RD];
   logic [MH-1:0]              r_mask_ff [RD], r_mask_in [RD];
   logic [ebs_pkg::END_W-1:0]  r_end_ff [RD], r_end_in [RD];

   logic [1:0]                 op_ff, op_in;
   logic [ebs_pkg::TAG_W-1:0]  tag_ff, tag_in;
   logic [ebs_pkg::REQH_W-1:0] hosts_ff, hosts_in;
   logic [ebs_pkg::WALL_W-1:0] wall_ff, wall_in;
   logic [ebs_pkg::NOW_W-1:0]  now_ff, now_in;

   logic [ebs_pkg::QC_W-1:0]   idx_ff, idx_in;
   logic [ebs_pkg::RA_W-1:0]   slot_ff, slot_in;
   logic [MH-1:0]              rem_ff, rem_in;
   logic [MH-1:0]              got_ff, got_in;
   logic [ebs_pkg::HOST_W-1:0] need_ff, need_in;
   logic [ebs_pkg::RA_W-1:0]   cand_ff, cand_in;
   logic [ebs_pkg::RA_W-1:0]   j_ff, j_in;
   logic [ebs_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic [ebs_pkg::END_W-1:0]  t_ff, t_in;
   logic [ebs_pkg::END_W-1:0]  shadow_ff, shadow_in;

   logic [1:0]                 kind_ff, kind_in;
   logic [ebs_pkg::TAG_W-1:0]  otag_ff, otag_in;
   logic [MH-1:0]              omask_ff, omask_in;
   logic                       last_ff, last_in;

   // Combinational helpers.
   logic [ebs_pkg::QA_W-1:0]   cur;
   logic [MH-1:0]              plat_mask;
   logic [MH-1:0]              held;
   logic [ebs_pkg::HOST_W-1:0] avail;
   logic [ebs_pkg::HOST_W-1:0] need_cur;
   logic                       slot_ok;
   logic [ebs_pkg::RA_W-1:0]   slot_free;
   logic                       cmp_hit;
   logic [ebs_pkg::RA_W-1:0]   cmp_slot;
   logic [ebs_pkg::END_W-1:0]  cur_end;
   logic [MH-1:0]              low_bit;
   logic [ebs_pkg::PLAT_W-1:0] plat_new;
   logic                       out_free;

   assign cur       = idx_ff[ebs_pkg::QA_W-1:0];
   assign plat_mask = ebs_pkg::plat_ones(plat_ff);
   assign avail     = ebs_pkg::popcount(free_ff);
   assign need_cur  = q_hosts_ff[cur];
   assign cur_end   = ebs_pkg::END_W'(now_ff) + ebs_pkg::END_W'(q_wall_ff[cur]);
   assign low_bit   = rem_ff & (~rem_ff + MH'(1));
   assign plat_new  = ebs_pkg::clamp_plat(csr_write_data);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      held      = '0;
      slot_ok   = 1'b0;
      slot_free = '0;
      cmp_hit   = 1'b0;
      cmp_slot  = '0;
      for (int i = RD - 1; i >= 0; i--) begin
         if (r_valid_ff[i]) held = held | r_mask_ff[i];
         if (!r_valid_ff[i]) begin
            slot_ok   = 1'b1;
            slot_free = ebs_pkg::RA_W'(i);
         end
         if (r_valid_ff[i] && r_tag_ff[i] == tag_ff) begin
            cmp_hit  = 1'b1;
            cmp_slot = ebs_pkg::RA_W'(i);
         end
      end
   end

   always_comb begin
      sts.op         = op_ff;
      sts.reject     = (hosts_ff > ebs_pkg::REQH_W'(plat_ff)) || (wall_ff == '0) ||
                       (q_cnt_ff >= ebs_pkg::QC_W'(QD));
      sts.q_empty    = (q_cnt_ff == '0);
      sts.avail_ok   = (avail >= need_cur);
      sts.cur_fits   = slot_ok && (avail >= need_cur);
      sts.cur_ends   = (cur_end <= shadow_ff);
      sts.idx_end    = (idx_ff >= q_cnt_ff);
      sts.alloc_done = (need_ff == '0);
      sts.cand_use   = r_valid_ff[cand_ff] && !(found_ff && r_end_ff[cand_ff] >= shadow_ff);
      sts.cand_last  = (cand_ff == ebs_pkg::RA_W'(RD - 1));
      sts.j_last     = (j_ff == ebs_pkg::RA_W'(RD - 1));
      sts.found      = found_ff;
      sts.out_free   = out_free;
   end

   always_comb begin
      plat_in    = plat_ff;
      free_in    = free_ff;
      q_cnt_in   = q_cnt_ff;
      r_valid_in = r_valid_ff;
      found_in   = found_ff;
      q_tag_in   = q_tag_ff;
      q_hosts_in = q_hosts_ff;
      q_wall_in  = q_wall_ff;
      r_tag_in   = r_tag_ff;
      r_mask_in  = r_mask_ff;
      r_end_in   = r_end_ff;
      op_in      = op_ff;
      tag_in     = tag_ff;
      hosts_in   = hosts_ff;
      wall_in    = wall_ff;
      now_in     = now_ff;
      idx_in     = idx_ff;
      slot_in    = slot_ff;
      rem_in     = rem_ff;
      got_in     = got_ff;
      need_in    = need_ff;
      cand_in    = cand_ff;
      j_in       = j_ff;
      sum_in     = sum_ff;
      t_in       = t_ff;
      shadow_in  = shadow_ff;

      if (csr_write_enable) begin
         plat_in = plat_new;
         free_in = ebs_pkg::plat_ones(plat_new) & ~held;
      end
      if (cmd.latch_in) begin
         op_in    = req_op;
         tag_in   = req_job_tag;
         hosts_in = req_hosts_requested;
         wall_in  = req_walltime;
         now_in   = req_now;
      end
      if (cmd.enqueue) begin
         q_tag_in[q_cnt_ff[ebs_pkg::QA_W-1:0]]   = tag_ff;
         q_hosts_in[q_cnt_ff[ebs_pkg::QA_W-1:0]] = hosts_ff[ebs_pkg::HOST_W-1:0];
         q_wall_in[q_cnt_ff[ebs_pkg::QA_W-1:0]]  = wall_ff;
         q_cnt_in = q_cnt_ff + ebs_pkg::QC_W'(1);
      end
      if (cmd.complete && cmp_hit) begin
         free_in              = free_ff | (r_mask_ff[cmp_slot] & plat_mask);
         r_valid_in[cmp_slot] = 1'b0;
      end
      if (cmd.idx_clr) idx_in = '0;
      if (cmd.idx_set1) idx_in = ebs_pkg::QC_W'(1);
      if (cmd.idx_inc) idx_in = idx_ff + ebs_pkg::QC_W'(1);
      if (cmd.found_clr) found_in = 1'b0;
      if (cmd.shadow_now) begin
         found_in  = 1'b1;
         shadow_in = ebs_pkg::END_W'(now_ff);
      end
      // Hosts are picked one per cycle, lowest free host first.
      if (cmd.alloc_init) begin
         slot_in = slot_free;
         rem_in  = free_ff;
         got_in  = '0;
         need_in = need_cur;
      end
      if (cmd.alloc_step) begin
         got_in  = got_ff | low_bit;
         rem_in  = rem_ff & ~low_bit;
         need_in = need_ff - ebs_pkg::HOST_W'(1);
      end
      if (cmd.launch) begin
         r_valid_in[slot_ff] = 1'b1;
         r_tag_in[slot_ff]   = q_tag_ff[cur];
         r_mask_in[slot_ff]  = got_ff;
         r_end_in[slot_ff]   = cur_end;
         free_in             = free_ff & ~got_ff;
         for (int e = 0; e < QD - 1; e++) begin
            if (ebs_pkg::QC_W'(e) >= idx_ff) begin
               q_tag_in[e]   = q_tag_ff[e + 1];
               q_hosts_in[e] = q_hosts_ff[e + 1];
               q_wall_in[e]  = q_wall_ff[e + 1];
            end
         end
         q_cnt_in = q_cnt_ff - ebs_pkg::QC_W'(1);
      end
      if (cmd.cand_clr) cand_in = '0;
      if (cmd.cand_inc) cand_in = cand_ff + ebs_pkg::RA_W'(1);
      if (cmd.sum_init) begin
         t_in   = r_end_ff[cand_ff];
         sum_in = ebs_pkg::SUM_W'(avail);
         j_in   = '0;
      end
      if (cmd.sum_step) begin
         if (r_valid_ff[j_ff] && r_end_ff[j_ff] <= t_ff) begin
            sum_in = sum_ff + ebs_pkg::SUM_W'(ebs_pkg::popcount(r_mask_ff[j_ff] & plat_mask));
         end
         j_in = j_ff + ebs_pkg::RA_W'(1);
      end
      if (cmd.sh_test && sum_ff >= ebs_pkg::SUM_W'(need_cur)) begin
         found_in  = 1'b1;
         shadow_in = t_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      otag_in      = otag_ff;
      omask_in     = omask_ff;
      last_in      = last_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         kind_in      = cmd.kind;
         unique case (cmd.kind)
            ebs_pkg::KIND_LAUNCH: begin
               otag_in  = q_tag_ff[cur];
               omask_in = got_ff;
               last_in  = 1'b0;
            end
            ebs_pkg::KIND_REJECT: begin
               otag_in  = tag_ff;
               omask_in = '0;
               last_in  = 1'b1;
            end
            default: begin
               otag_in  = '0;
               omask_in = '0;
               last_in  = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plat_ff      <= ebs_pkg::PLAT_W'(MH);
         free_ff      <= ebs_pkg::plat_ones(ebs_pkg::PLAT_W'(MH));
         q_cnt_ff     <= '0;
         r_valid_ff   <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         plat_ff      <= plat_in;
         free_ff      <= free_in;
         q_cnt_ff     <= q_cnt_in;
         r_valid_ff   <= r_valid_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_tag_ff   <= q_tag_in;
      q_hosts_ff <= q_hosts_in;
      q_wall_ff  <= q_wall_in;
      r_tag_ff   <= r_tag_in;
      r_mask_ff  <= r_mask_in;
      r_end_ff   <= r_end_in;
      op_ff      <= op_in;
      tag_ff     <= tag_in;
      hosts_ff   <= hosts_in;
      wall_ff    <= wall_in;
      now_ff     <= now_in;
      idx_ff     <= idx_in;
      slot_ff    <= slot_in;
      rem_ff     <= rem_in;
      got_ff     <= got_in;
      need_ff    <= need_in;
      cand_ff    <= cand_in;
      j_ff       <= j_in;
      sum_ff     <= sum_in;
      t_ff       <= t_in;
      shadow_ff  <= shadow_in;
      kind_ff    <= kind_in;
      otag_ff    <= otag_in;
      omask_ff   <= omask_in;
      last_ff    <= last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_out_tag   = otag_ff;
   assign rsp_host_mask = omask_ff;
   assign rsp_last      = last_ff;

endmodule

// ----- hdl/easy_backfill_scheduler_unit.sv -----
// EASY backfill job scheduler, top level.
// Request beats carry an op: submit a job, report a completion, or run a pass.
// Result beats carry a launch, a reject or a pass-done marker; rsp_last marks
// the final beat caused by a request. Submits and completions that produce
// nothing go from decode straight back to idle; a rejected submit goes on to
// a reject state that loads its beat once the result register is free.
// In a scheduling pass, each launch allocates the job's hosts one per cycle
// and then issues its beat; backfill steps through the queue entries one at
// a time, and when the head job is blocked by hosts, one shadow search walks
// the running table once per candidate end time.
// One request is worked on at a time; req_ready is high only while idle.
// The result register lets the block go idle and take a new request while
// a finished beat still waits. When rsp_ready is low the pass holds at its
// next result until the waiting beat is taken; nothing is dropped.
// Reset empties the queue and running table, sets 64 platform hosts, all free.
// The user must write the platform register only while idle; it is not checked.
// Deps: ebs_pkg, ebs_ctrl, ebs_datapath, assertion macro header.
`timescale 1ns / 1ps
`include "easy_backfill_scheduler_unit_assert.svh"

module easy_backfill_scheduler_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_job_tag,
   input  logic [15:0] req_hosts_requested,
   input  logic [31:0] req_walltime,
   input  logic [39:0] req_now,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_out_tag,
   output logic [63:0] rsp_host_mask,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [6:0]  csr_write_data
);

   ebs_pkg::cmd_type cmd;
   ebs_pkg::sts_type sts;

   ebs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ebs_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_op              (req_op),
      .req_job_tag         (req_job_tag),
      .req_hosts_requested (req_hosts_requested),
      .req_walltime        (req_walltime),
      .req_now             (req_now),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_kind            (rsp_kind),
      .rsp_out_tag         (rsp_out_tag),
      .rsp_host_mask       (rsp_host_mask),
      .rsp_last            (rsp_last)
   );

   `EBS_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "request taken while busy")
   `EBS_ASSERT_IMP(a_last_on_non_launch, clock, reset, rsp_valid && rsp_kind != ebs_pkg::KIND_LAUNCH, rsp_last, "reject or done beat without last")
   `EBS_ASSERT_IMP(a_launch_not_last, clock, reset, rsp_valid && rsp_kind == ebs_pkg::KIND_LAUNCH, !rsp_last, "launch beat marked last")

endmodule

// ----- tb/tb_easy_backfill_scheduler_unit.sv -----
// Self-checking testbench for the EASY backfill scheduler unit.
// Needs ebs_pkg and easy_backfill_scheduler_unit. It runs a directed table and
// then random traffic, and checks each result beat against a built-in predictor.
`timescale 1ns / 1ps

module tb_easy_backfill_scheduler_unit;

   typedef struct {
      ebs_pkg::op_type   op;
      logic [7:0]        tag;
      logic [15:0]       hosts;
      logic [31:0]       wall;
      logic [39:0]       now;
      bit                typed;
      ebs_pkg::kind_type kind_e;
   } job_req_type;

   typedef struct {
      ebs_pkg::kind_type kind;
      logic [7:0]        tag;
      logic [63:0]       mask;
      logic              last;
   } beat_type;

   logic        clock = 0, reset = 1;
   logic        req_valid = 0, req_ready;
   logic [1:0]  req_op = 0;
   logic [7:0]  req_job_tag = 0;
   logic [15:0] req_hosts_requested = 0;
   logic [31:0] req_walltime = 0;
   logic [39:0] req_now = 0;
   logic        rsp_valid, rsp_ready = 0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_out_tag;
   logic [63:0] rsp_host_mask;
   logic        rsp_last;
   logic        csr_write_enable = 0;
   logic [6:0]  csr_write_data = 0;

   easy_backfill_scheduler_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_job_tag(req_job_tag), .req_hosts_requested(req_hosts_requested),
      .req_walltime(req_walltime), .req_now(req_now),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_kind(rsp_kind),
      .rsp_out_tag(rsp_out_tag), .rsp_host_mask(rsp_host_mask), .rsp_last(rsp_last),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end

   // Scheduler state as the predictor sees it.
   logic [6:0]  plat;
   logic [7:0]  wq_tag [ebs_pkg::QUEUE_DEPTH];
   logic [6:0]  wq_hosts [ebs_pkg::QUEUE_DEPTH];
   logic [31:0] wq_wall [ebs_pkg::QUEUE_DEPTH];
   int          wq_n;
   bit          job_on [ebs_pkg::RUN_DEPTH];
   logic [7:0]  job_tag [ebs_pkg::RUN_DEPTH];
   logic [63:0] job_mask [ebs_pkg::RUN_DEPTH];
   logic [40:0] job_end [ebs_pkg::RUN_DEPTH];
   logic [63:0] idle_hosts;

   beat_type    sched_beats[$];
   int          errors = 0, n_launch = 0, n_reject = 0, n_pass = 0;
   int          send_idle = 0, recv_idle = 0, hold_cycles = 0;
   logic [39:0] clock_ticks = 0;

   function automatic logic [63:0] plat_hosts();
      return (plat >= 64) ? '1 : ((64'd1 << plat) - 64'd1);
   endfunction

   function automatic int open_slot();
      for (int i = 0; i < ebs_pkg::RUN_DEPTH; i++) if (!job_on[i]) return i;
      return -1;
   endfunction

   function automatic void add_beat(ebs_pkg::kind_type k, logic [7:0] t, logic [63:0] m);
      beat_type b;
      b.kind = k; b.tag = t; b.mask = m; b.last = 0;
      sched_beats.insert(sched_beats.size(), b);
   endfunction

   function automatic void start_job(int idx, int s, logic [39:0] now);
      logic [63:0] got;
      int need;
      got = 0;
      need = wq_hosts[idx];
      for (int b = 0; b < 64 && need > 0; b++) begin
         if (idle_hosts[b]) begin
            got[b] = 1;
            need--;
         end
      end
      idle_hosts &= ~got;
      job_on[s] = 1;
      job_tag[s] = wq_tag[idx];
      job_mask[s] = got;
      job_end[s] = {1'b0, now} + {9'd0, wq_wall[idx]};
      add_beat(ebs_pkg::KIND_LAUNCH, wq_tag[idx], got);
      for (int i = idx; i + 1 < wq_n; i++) begin
         wq_tag[i] = wq_tag[i + 1];
         wq_hosts[i] = wq_hosts[i + 1];
         wq_wall[i] = wq_wall[i + 1];
      end
      wq_n--;
   endfunction

   function automatic void run_pass(logic [39:0] now);
      int s, avail, need, sum, i;
      bit found, fits;
      logic [40:0] shadow, t;
      while (wq_n > 0) begin
         s = open_slot();
         if (s < 0 || $countones(idle_hosts) < wq_hosts[0]) break;
         start_job(0, s, now);
      end
      if (wq_n > 0) begin
         need = wq_hosts[0];
         avail = $countones(idle_hosts);
         found = 0;
         shadow = 0;
         if (avail >= need) begin
            found = 1;
            shadow = {1'b0, now};
         end else begin
            // Earliest end time by which enough hosts come back for the head job.
            for (int c = 0; c < ebs_pkg::RUN_DEPTH; c++) begin
               if (!job_on[c]) continue;
               t = job_end[c];
               if (found && t >= shadow) continue;
               sum = avail;
               for (int j = 0; j < ebs_pkg::RUN_DEPTH; j++)
                  if (job_on[j] && job_end[j] <= t)
                     sum += $countones(job_mask[j] & plat_hosts());
               if (sum >= need) begin
                  found = 1;
                  shadow = t;
               end
            end
         end
         if (found) begin
            i = 1;
            while (i < wq_n) begin
               s = open_slot();
               fits = s >= 0 && $countones(idle_hosts) >= wq_hosts[i];
               if (fits && ({1'b0, now} + {9'd0, wq_wall[i]} <= shadow)) start_job(i, s, now);
               else i++;
            end
         end
      end
      add_beat(ebs_pkg::KIND_DONE, 8'd0, 64'd0);
   endfunction

   // Updates the predicted state for one request and returns its beat count.
   function automatic int predict(job_req_type r);
      int n0;
      n0 = sched_beats.size();
      case (r.op)
         ebs_pkg::OP_SUBMIT: begin
            if (r.hosts > {9'd0, plat} || r.wall == 0 || wq_n >= ebs_pkg::QUEUE_DEPTH) begin
               add_beat(ebs_pkg::KIND_REJECT, r.tag, 64'd0);
            end else begin
               wq_tag[wq_n] = r.tag;
               wq_hosts[wq_n] = r.hosts[6:0];
               wq_wall[wq_n] = r.wall;
               wq_n++;
            end
         end
         ebs_pkg::OP_COMPLETE: begin
            for (int i = 0; i < ebs_pkg::RUN_DEPTH; i++) begin
               if (job_on[i] && job_tag[i] == r.tag) begin
                  idle_hosts |= job_mask[i] & plat_hosts();
                  job_on[i] = 0;
                  break;
               end
            end
         end
         ebs_pkg::OP_SCHEDULE: run_pass(r.now);
         default: ;
      endcase
      if (sched_beats.size() > n0) sched_beats[$].last = 1;
      return sched_beats.size() - n0;
   endfunction

   task automatic send(job_req_type r);
      int n;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_op <= r.op;
      req_job_tag <= r.tag;
      req_hosts_requested <= r.hosts;
      req_walltime <= r.wall;
      req_now <= r.now;
      do @(posedge clock); while (!(req_valid && req_ready));
      n = predict(r);
      if (r.typed && (n != 1 || sched_beats[$].kind != r.kind_e ||
                      sched_beats[$].tag != r.tag || sched_beats[$].mask != 0)) begin
         $error("typed row op %0d tag %0h: predictor disagrees with table", r.op, r.tag);
         errors++;
      end
      @(negedge clock);
   endtask

   function automatic job_req_type mk(ebs_pkg::op_type op, logic [7:0] tag,
                                      logic [15:0] hosts, logic [31:0] wall,
                                      logic [39:0] now);
      job_req_type r;
      r.op = op; r.tag = tag; r.hosts = hosts; r.wall = wall; r.now = now;
      r.typed = 0; r.kind_e = ebs_pkg::KIND_DONE;
      return r;
   endfunction

   function automatic job_req_type mk_typed(job_req_type r, ebs_pkg::kind_type k);
      r.typed = 1;
      r.kind_e = k;
      return r;
   endfunction

   // Waits for the block to drain, then writes the platform register.
   task automatic set_platform(logic [6:0] v);
      req_valid <= 0;
      while (sched_beats.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      csr_write_enable <= 1;
      csr_write_data <= v;
      @(negedge clock);
      csr_write_enable <= 0;
      plat = (v == 0) ? 7'd1 : (v > 7'd64) ? 7'd64 : v;
      idle_hosts = plat_hosts();
      for (int i = 0; i < ebs_pkg::RUN_DEPTH; i++) if (job_on[i]) idle_hosts &= ~job_mask[i];
   endtask

   task automatic random_item();
      job_req_type r;
      int pick, s;
      pick = $urandom_range(99);
      r = mk(ebs_pkg::op_type'(2'd3), 8'($urandom), 16'($urandom), $urandom,
             40'({$urandom, $urandom}));
      if (pick < 45) begin
         r.op = ebs_pkg::OP_SUBMIT;
         r.hosts = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(0, plat));
         case ($urandom_range(19))
            0: r.wall = 0;
            1: r.wall = $urandom;
            default: r.wall = $urandom_range(1, 200);
         endcase
      end else if (pick < 65) begin
         r.op = ebs_pkg::OP_COMPLETE;
         s = $urandom_range(ebs_pkg::RUN_DEPTH - 1);
         if (job_on[s] && $urandom_range(9) != 0) r.tag = job_tag[s];
      end else if (pick < 96) begin
         r.op = ebs_pkg::OP_SCHEDULE;
         clock_ticks += 40'($urandom_range(0, 60));
         if ($urandom_range(29) != 0) r.now = clock_ticks;
      end
      send(r);
   endtask

   // Receiver: random stalls, plus a long hold-off on request.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 0;
            hold_cycles--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   always @(posedge clock) begin
      beat_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (sched_beats.size() == 0) begin
            $error("result beat with nothing expected: kind %0d tag %0h", rsp_kind, rsp_out_tag);
            errors++;
         end else begin
            e = sched_beats.pop_front();
            if (rsp_kind != e.kind) begin
               $error("kind: expected %0d, got %0d", e.kind, rsp_kind);
               errors++;
            end
            if (rsp_out_tag != e.tag) begin
               $error("out_tag: expected %0h, got %0h", e.tag, rsp_out_tag);
               errors++;
            end
            if (rsp_host_mask != e.mask) begin
               $error("host_mask: expected %h, got %h", e.mask, rsp_host_mask);
               errors++;
            end
            if (rsp_last != e.last) begin
               $error("last: expected %0d, got %0d", e.last, rsp_last);
               errors++;
            end
            case (e.kind)
               ebs_pkg::KIND_LAUNCH: n_launch++;
               ebs_pkg::KIND_REJECT: n_reject++;
               default: n_pass++;
            endcase
         end
      end
   end

   job_req_type directed[$];

   initial begin
      plat = 64;
      wq_n = 0;
      idle_hosts = '1;
      for (int i = 0; i < ebs_pkg::RUN_DEPTH; i++) job_on[i] = 0;
      send_idle = 9;
      recv_idle = 69;
      repeat (8) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      directed = '{
         mk_typed(mk(ebs_pkg::OP_SCHEDULE, 8'h00, 0, 0, 0), ebs_pkg::KIND_DONE),
         mk_typed(mk(ebs_pkg::OP_SUBMIT, 8'hFF, 65, 5, 0), ebs_pkg::KIND_REJECT),
         mk_typed(mk(ebs_pkg::OP_SUBMIT, 8'h01, 10, 0, 0), ebs_pkg::KIND_REJECT),
         mk_typed(mk(ebs_pkg::OP_SUBMIT, 8'hAA, 16'hFFFF, 32'hFFFF_FFFF, 0),
                  ebs_pkg::KIND_REJECT),
         mk(ebs_pkg::OP_SUBMIT, 8'h10, 64, 100, 0),
         mk(ebs_pkg::OP_SCHEDULE, 8'h00, 0, 0, 0),
         mk(ebs_pkg::OP_SUBMIT, 8'h11, 8, 50, 0),
         mk(ebs_pkg::OP_SUBMIT, 8'h12, 0, 10, 0),
         mk(ebs_pkg::OP_SUBMIT, 8'h13, 4, 200, 0),
         mk(ebs_pkg::OP_SCHEDULE, 8'h00, 0, 0, 10),
         mk(ebs_pkg::OP_COMPLETE, 8'h77, 0, 0, 0),
         mk(ebs_pkg::op_type'(2'd3), 8'h55, 16'h5555, 32'h5555_5555, 40'h55_5555_5555),
         mk(ebs_pkg::OP_COMPLETE, 8'h10, 0, 0, 0),
         mk(ebs_pkg::OP_SCHEDULE, 8'h00, 0, 0, 40'hFF_FFFF_FFF0),
         mk(ebs_pkg::OP_SUBMIT, 8'h20, 60, 32'hFFFF_FFFF, 0),
         mk(ebs_pkg::OP_SUBMIT, 8'h21, 1, 1, 0),
         mk(ebs_pkg::OP_SCHEDULE, 8'h00, 0, 0, 40'hFF_FFFF_FFFF),
         mk(ebs_pkg::OP_SUBMIT, 8'h30, 2, 7, 0),
         mk(ebs_pkg::OP_SUBMIT, 8'h30, 3, 9, 0),
         mk(ebs_pkg::OP_SCHEDULE, 8'h00, 0, 0, 40'hFF_FFFF_FFFF),
         mk(ebs_pkg::OP_COMPLETE, 8'h30, 0, 0, 0),
         mk(ebs_pkg::OP_COMPLETE, 8'h11, 0, 0, 0),
         mk(ebs_pkg::OP_COMPLETE, 8'h13, 0, 0, 0),
         mk(ebs_pkg::OP_SCHEDULE, 8'h00, 0, 0, 40'h12_3456_789A),
         mk(ebs_pkg::OP_COMPLETE, 8'h20, 0, 0, 0)
      };
      foreach (directed[i]) send(directed[i]);

      set_platform(7'd0);
      repeat (10) random_item();

      // Zero-host jobs fill the queue, then the running table.
      set_platform(7'd127);
      for (int i = 0; i < 33; i++)
         send(mk(ebs_pkg::OP_SUBMIT, 8'(i + 64), 0, $urandom_range(1, 90), 0));
      send(mk(ebs_pkg::OP_SCHEDULE, 0, 0, 0, clock_ticks));
      send(mk(ebs_pkg::OP_SUBMIT, 8'hEE, 0, 5, 0));
      send(mk(ebs_pkg::OP_SUBMIT, 8'hEF, 3, 5, 0));
      send(mk(ebs_pkg::OP_SCHEDULE, 0, 0, 0, clock_ticks));
      for (int i = 0; i < 32; i++) send(mk(ebs_pkg::OP_COMPLETE, 8'(i + 64), 0, 0, 0));
      send(mk(ebs_pkg::OP_SCHEDULE, 0, 0, 0, clock_ticks));

      send_idle = 69;
      recv_idle = 9;
      set_platform(7'd37);
      repeat (10) random_item();
      hold_cycles = 400;
      repeat (15) random_item();

      send_idle = 0;
      recv_idle = 0;
      set_platform(7'd13);
      repeat (20) random_item();
      set_platform(7'd64);
      repeat (10) random_item();

      req_valid <= 0;
      while (sched_beats.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Checked %0d launches, %0d rejects and %0d scheduling passes", n_launch,
               n_reject, n_pass);
      $display("across platform sizes 1, 13, 37 and 64 with full queue and table.");
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- easy_backfill_scheduler_unit.f -----
+incdir+hdl
hdl/ebs_pkg.sv
hdl/ebs_ctrl.sv
hdl/ebs_datapath.sv
hdl/easy_backfill_scheduler_unit.sv
tb/tb_easy_backfill_scheduler_unit.sv
